### rtl/core/rcd_pkg.sv
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared types and constants of the reversible circular deque: opcodes,
// status codes, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package rcd_pkg;

    // default sizing
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // stream word widths
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

    // input field placement
    localparam int IN_OP_LSB    = 0;
    localparam int IN_OP_W      = 4;
    localparam int IN_VALUE_LSB = 4;
    localparam int IN_VALUE_W   = 32;
    localparam int IN_INDEX_LSB = 36;
    localparam int IN_INDEX_W   = 6;

    // output field widths
    localparam int OUT_RD_W    = 32;
    localparam int OUT_POS_W   = 6;
    localparam int OUT_STS_W   = 3;
    localparam int OUT_CNT_W   = 7;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_RD_W - OUT_POS_W - OUT_STS_W - OUT_CNT_W - 1;

    typedef enum logic [3:0] {
        OP_ADD_END   = 4'd0,
        OP_ADD_FRONT = 4'd1,
        OP_DEL_END   = 4'd2,
        OP_DEL_FRONT = 4'd3,
        OP_READ      = 4'd4,
        OP_WRITE     = 4'd5,
        OP_TOGGLE    = 4'd6,
        OP_CLEAR     = 4'd7,
        OP_FIND      = 4'd8
    } t_opcode;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_FULL     = 3'd1,
        STS_EMPTY    = 3'd2,
        STS_BADIDX   = 3'd3,
        STS_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_FIND_ADDR,
        S_FIND_CMP,
        S_RESULT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic exec;
        logic read_cap;
        logic find_cmp;
        logic load_out;
        logic from_exec;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic op_read_ok;
        logic op_find_go;
        logic find_hit;
        logic find_last;
        logic out_free;
    } t_dp_sts;

endpackage

### rtl/core/rcd_ram.sv
// ----------------------------------------------------------------------------
// rcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/rcd_ctrl.sv
// ----------------------------------------------------------------------------
// rcd_ctrl
// Sequencer of the deque: takes one word, runs it through execute, read or
// search steps and hands the result to the output register.
// ----------------------------------------------------------------------------
module rcd_ctrl
    import rcd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    s_axis_tvalid,
    output logic    s_axis_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.op_read_ok) begin
                    n_state = S_READ;
                end else if (i_sts.op_find_go) begin
                    n_state = S_FIND_ADDR;
                end else if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_READ: begin
                n_state = S_RESULT;
            end
            S_FIND_ADDR: begin
                n_state = S_FIND_CMP;
            end
            S_FIND_CMP: begin
                if (i_sts.find_hit || i_sts.find_last) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_FIND_ADDR;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd         = '0;
        s_axis_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready  = 1'b1;
                o_cmd.latch_in = s_axis_tvalid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (!i_sts.op_read_ok && !i_sts.op_find_go && i_sts.out_free) begin
                    o_cmd.load_out  = 1'b1;
                    o_cmd.from_exec = 1'b1;
                end
            end
            S_READ: begin
                o_cmd.read_cap = 1'b1;
            end
            S_FIND_ADDR: begin
                o_cmd = '0;
            end
            S_FIND_CMP: begin
                o_cmd.find_cmp = 1'b1;
            end
            S_RESULT: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### rtl/core/rcd_dpath.sv
// ----------------------------------------------------------------------------
// rcd_dpath
// Datapath of the deque: ring pointers, fill count, view flag, slot RAM,
// search iterator, held result and the output register.
// ----------------------------------------------------------------------------
module rcd_dpath
    import rcd_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   m_axis_tready,
    output logic                   m_axis_tvalid,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > OUT_CNT_W) ? CW : OUT_CNT_W;
    localparam logic [PW:0]   DEPTH_X = (PW + 1)'(DEPTH);
    localparam logic [PW-1:0] LAST_P  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

    // latched input word
    t_opcode               r_op;
    logic [DATA_WIDTH-1:0] r_value;
    logic [IN_INDEX_W-1:0] r_index;

    // deque state
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic          r_rev, n_rev;

    // held result and search iterator
    t_status              r_status;
    logic [OUT_RD_W-1:0]  r_rd;
    logic [OUT_POS_W-1:0] r_pos;
    logic [PW-1:0]        r_iter;

    // output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // ram ports
    logic                  mem_we;
    logic [PW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [PW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    // misc
    logic [63:0]           vin64;
    logic [63:0]           rd64;
    logic [XW-1:0]         idx_x;
    logic [XW-1:0]         iter_x;
    logic [XW-1:0]         iter_nx;
    logic [XW-1:0]         count_x;
    logic [PW-1:0]         idx_slot;
    logic [PW-1:0]         iter_slot;
    logic [PW-1:0]         head_dec;
    logic [PW-1:0]         tail_inc;
    logic                  idx_ok;
    logic                  is_full;
    logic                  is_empty;
    logic                  push_head;
    logic                  pop_head;
    t_status               exec_status;
    t_status               out_status;
    logic [OUT_RD_W-1:0]   out_rd;
    logic [OUT_POS_W-1:0]  out_pos;
    logic [XW-1:0]         out_cnt_x;

    // logical index to physical slot
    function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] k,
                                              input logic [PW-1:0] head,
                                              input logic [PW-1:0] tail,
                                              input logic          rev);
        logic [PW:0] s;
        if (!rev) begin
            s = {1'b0, head} + {1'b0, k};
            if (s >= DEPTH_X) begin
                s = s - DEPTH_X;
            end
        end else if (tail >= k) begin
            s = {1'b0, tail} - {1'b0, k};
        end else begin
            s = {1'b0, tail} + DEPTH_X - {1'b0, k};
        end
        return s[PW-1:0];
    endfunction

    assign vin64     = {32'd0, s_axis_tdata[IN_VALUE_LSB +: IN_VALUE_W]};
    assign rd64      = 64'(mem_rdata);
    assign idx_x     = XW'(r_index);
    assign iter_x    = XW'(r_iter);
    assign iter_nx   = iter_x + XW'(1);
    assign count_x   = XW'(r_count);
    assign idx_ok    = idx_x < count_x;
    assign is_full   = (r_count == FULL_C);
    assign is_empty  = (r_count == '0);
    assign idx_slot  = slot_of(idx_x[PW-1:0], r_head, r_tail, r_rev);
    assign iter_slot = slot_of(r_iter, r_head, r_tail, r_rev);
    assign head_dec  = (r_head == '0) ? LAST_P : r_head - 1'b1;
    assign tail_inc  = (r_tail == LAST_P) ? '0 : r_tail + 1'b1;
    assign push_head = (r_op == OP_ADD_END) ? r_rev : !r_rev;
    assign pop_head  = (r_op == OP_DEL_END) ? r_rev : !r_rev;

    // read address: indexed access during execute, search slot otherwise
    assign mem_raddr = i_cmd.exec ? idx_slot : iter_slot;

    // execute step: state update, ram write and immediate status
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_rev       = r_rev;
        exec_status = STS_OK;
        mem_we      = 1'b0;
        mem_waddr   = idx_slot;
        mem_wdata   = r_value;
        if (i_cmd.exec) begin
            case (r_op)
                OP_ADD_END, OP_ADD_FRONT: begin
                    if (is_full) begin
                        exec_status = STS_FULL;
                    end else begin
                        mem_we  = 1'b1;
                        n_count = r_count + 1'b1;
                        if (is_empty) begin
                            n_head    = '0;
                            n_tail    = '0;
                            mem_waddr = '0;
                        end else if (push_head) begin
                            n_head    = head_dec;
                            mem_waddr = head_dec;
                        end else begin
                            n_tail    = tail_inc;
                            mem_waddr = tail_inc;
                        end
                    end
                end
                OP_DEL_END, OP_DEL_FRONT: begin
                    if (is_empty) begin
                        exec_status = STS_EMPTY;
                    end else begin
                        n_count = r_count - 1'b1;
                        if (pop_head) begin
                            n_head = (r_head == LAST_P) ? '0 : r_head + 1'b1;
                        end else begin
                            n_tail = (r_tail == '0) ? LAST_P : r_tail - 1'b1;
                        end
                    end
                end
                OP_READ: begin
                    if (!idx_ok) begin
                        exec_status = STS_BADIDX;
                    end
                end
                OP_WRITE: begin
                    if (!idx_ok) begin
                        exec_status = STS_BADIDX;
                    end else begin
                        mem_we = 1'b1;
                    end
                end
                OP_TOGGLE: begin
                    n_rev = !r_rev;
                end
                OP_CLEAR: begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                    n_rev   = 1'b0;
                end
                OP_FIND: begin
                    exec_status = STS_NOTFOUND;
                end
                default: begin
                    exec_status = STS_OK;
                end
            endcase
        end
    end

    // deque state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_rev   <= n_rev;
        end
    end

    // input latch, held result and search iterator
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op    <= t_opcode'(s_axis_tdata[IN_OP_LSB +: IN_OP_W]);
            r_value <= vin64[DATA_WIDTH-1:0];
            r_index <= s_axis_tdata[IN_INDEX_LSB +: IN_INDEX_W];
        end
        if (i_cmd.exec) begin
            r_status <= exec_status;
            r_rd     <= '0;
            r_pos    <= '0;
            r_iter   <= '0;
        end
        if (i_cmd.read_cap) begin
            r_rd <= rd64[OUT_RD_W-1:0];
        end
        if (i_cmd.find_cmp) begin
            if (o_sts.find_hit) begin
                r_status <= STS_OK;
                r_pos    <= iter_x[OUT_POS_W-1:0];
            end else if (!o_sts.find_last) begin
                r_iter <= r_iter + 1'b1;
            end
        end
    end

    // result word selection
    assign out_status = i_cmd.from_exec ? exec_status : r_status;
    assign out_rd     = i_cmd.from_exec ? '0 : r_rd;
    assign out_pos    = i_cmd.from_exec ? '0 : r_pos;
    assign out_cnt_x  = XW'(n_count);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {{OUT_PAD_W{1'b0}}, n_rev, out_cnt_x[OUT_CNT_W-1:0],
                           out_status, out_pos, out_rd};
        end
    end

    // status toward the controller
    assign o_sts.op_read_ok = (r_op == OP_READ) && idx_ok;
    assign o_sts.op_find_go = (r_op == OP_FIND) && !is_empty;
    assign o_sts.find_hit   = (mem_rdata == r_value);
    assign o_sts.find_last  = (iter_nx == count_x);
    assign o_sts.out_free   = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    rcd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

### rtl/core/reversible_circular_deque_unit.sv
// ----------------------------------------------------------------------------
// reversible_circular_deque_unit
// Fixed-capacity ring deque with a reverse view, driven by one opcode word
// per operation and answering with one result word per operation.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries command words (opcode, value, index); m_axis returns one
//   result word per command (read data, position, status, count, view flag).
//   Commands are taken one at a time. Steps from issue to result register:
//     add, delete, write, toggle, clear, bad index, find on empty: execute
//     read: execute, then one registered ram read, then the result step
//     find: execute, then per entry an address step and a compare step, for
//     k entries compared, at most the fill count, then the result step
//   The result register sits between the two sides, so a new command is
//   taken while an earlier result waits; a command only stalls in its last
//   step when the result register is still full and m_axis_tready is low.
//   Reset (synchronous, active low) empties the deque, clears the reverse
//   view and drops any pending result. Slot contents are not cleared; only
//   slots that were added or written are ever read.
// ----------------------------------------------------------------------------
module reversible_circular_deque_unit
    import rcd_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // command word
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // opcode[3:0], value[35:4], index[41:36]
    // result word
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // read_data[31:0], position[37:32],
                                                   // status[40:38], element_count[47:41],
                                                   // reversed_now[48]
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    rcd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_sts         (dp_sts),
        .o_cmd         (dp_cmd)
    );

    rcd_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts)
    );

    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load_out |-> dp_sts.out_free)
        else $error("result register overwritten");

    // a command word is never taken while another is executing
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.latch_in |-> !dp_cmd.exec && !dp_cmd.find_cmp && !dp_cmd.read_cap)
        else $error("command taken during execution");

    // read data is zero unless the status is ok
    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[40:38] != STS_OK) |-> m_axis_tdata[31:0] == '0)
        else $error("read data on failed operation");

    // a position is reported only with an ok status
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[40:38] != STS_OK) |-> m_axis_tdata[37:32] == '0)
        else $error("position on failed operation");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the reversible circular deque. A directed opening
// walks the corner cases (empty deletes, bad indexes, reversed adds, spare
// opcodes, clear), then phases of growth, drain and mixed traffic run the
// ring through full and empty. A scoreboard predicts every result word and
// compares it field by field; both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb;
    import rcd_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int PTR_W          = $clog2(DEPTH);
    localparam int RANDOM_ITEMS   = 925;
    localparam int CALM_ITEMS     = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 200;

    // opcodes past find are accepted and ignored
    localparam logic [3:0] OP_SPARE_FIRST = 4'd9;
    localparam logic [3:0] OP_SPARE_LAST  = 4'd15;

    typedef enum int {
        MIX_GROW,
        MIX_DRAIN,
        MIX_ANY
    } t_mix;

    typedef struct {
        logic [3:0]  opcode;
        logic [31:0] value;
        logic [5:0]  index;
    } t_cmd;

    typedef struct {
        logic [31:0] read_data;
        logic [5:0]  position;
        t_status     status;
        logic [6:0]  element_count;
        logic        reversed_now;
    } t_result;

    // ------------------------------------------------------------------------
    // deque predictor and result checker
    // ------------------------------------------------------------------------
    class deque_scoreboard;
        logic [31:0]      slots [DEPTH];
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
        int unsigned      fill;
        bit               rev;
        t_result          pending_results [$];
        int unsigned      errors;
        int unsigned      commands;
        int unsigned      checked;
        int unsigned      status_seen [8];

        function new();
            head   = '0;
            tail   = '0;
            fill   = 0;
            rev    = 1'b0;
            errors = 0;
            commands = 0;
            checked  = 0;
            foreach (slots[i]) slots[i] = '0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // logical index to ring slot, following the view
        function logic [PTR_W-1:0] slot_of(int unsigned i);
            logic [PTR_W-1:0] k;
            k = i[PTR_W-1:0];
            return rev ? tail - k : head + k;
        endfunction

        function logic [31:0] element_at(int unsigned i);
            return slots[slot_of(i)];
        endfunction

        function t_status push_word(bit at_head, logic [31:0] v);
            if (fill >= DEPTH) return STS_FULL;
            if (fill == 0) begin
                head     = '0;
                tail     = '0;
                slots[0] = v;
            end else if (at_head) begin
                head        = head - 1'b1;
                slots[head] = v;
            end else begin
                tail        = tail + 1'b1;
                slots[tail] = v;
            end
            fill++;
            return STS_OK;
        endfunction

        function t_status pop_word(bit at_head);
            if (fill == 0) return STS_EMPTY;
            if (at_head) head = head + 1'b1;
            else tail = tail - 1'b1;
            fill--;
            return STS_OK;
        endfunction

        // accepted command: update the model and queue its result
        function void note_command(t_cmd c);
            t_result r;
            r.read_data = '0;
            r.position  = '0;
            r.status    = STS_OK;
            case (c.opcode)
                OP_ADD_END:   r.status = push_word(rev, c.value);
                OP_ADD_FRONT: r.status = push_word(!rev, c.value);
                OP_DEL_END:   r.status = pop_word(rev);
                OP_DEL_FRONT: r.status = pop_word(!rev);
                OP_READ: begin
                    if (c.index >= fill) r.status = STS_BADIDX;
                    else r.read_data = element_at(c.index);
                end
                OP_WRITE: begin
                    if (c.index >= fill) r.status = STS_BADIDX;
                    else slots[slot_of(c.index)] = c.value;
                end
                OP_TOGGLE: rev = !rev;
                OP_CLEAR: begin
                    head = '0;
                    tail = '0;
                    fill = 0;
                    rev  = 1'b0;
                end
                OP_FIND: begin
                    r.status = STS_NOTFOUND;
                    for (int unsigned i = 0; i < fill; i++) begin
                        if (element_at(i) == c.value) begin
                            r.position = i[5:0];
                            r.status   = STS_OK;
                            break;
                        end
                    end
                end
                default: ;
            endcase
            r.element_count = fill[6:0];
            r.reversed_now  = rev;
            pending_results.push_back(r);
            status_seen[r.status]++;
            commands++;
        endfunction

        function void check_word(logic [OUT_TDATA_W-1:0] w);
            t_result exp_r;
            logic [31:0] rd;
            logic [5:0]  pos;
            logic [2:0]  sts;
            logic [6:0]  cnt;
            logic        rv;
            rd  = w[31:0];
            pos = w[37:32];
            sts = w[40:38];
            cnt = w[47:41];
            rv  = w[48];
            if (pending_results.size() == 0) begin
                $error("result word with no command pending: %0h", w);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            checked++;
            if (rd !== exp_r.read_data) begin
                $error("read_data mismatch: expected %0h, got %0h", exp_r.read_data, rd);
                errors++;
            end
            if (pos !== exp_r.position) begin
                $error("position mismatch: expected %0d, got %0d", exp_r.position, pos);
                errors++;
            end
            if (sts !== exp_r.status) begin
                $error("status mismatch: expected %0d, got %0d", exp_r.status, sts);
                errors++;
            end
            if (cnt !== exp_r.element_count) begin
                $error("element_count mismatch: expected %0d, got %0d",
                       exp_r.element_count, cnt);
                errors++;
            end
            if (rv !== exp_r.reversed_now) begin
                $error("reversed_now mismatch: expected %0b, got %0b", exp_r.reversed_now, rv);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals and block
    // ------------------------------------------------------------------------
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // opcode, value, index
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // read_data, position, status,
                                                  // element_count, reversed_now

    deque_scoreboard sb;
    bit              idle_on     = 1'b1;
    int unsigned     stall_left  = 0;
    int unsigned     quiet_count = 0;

    reversible_circular_deque_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // result side backpressure in short bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(1, 5) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // check each accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_count <= 0;
        end else begin
            quiet_count <= quiet_count + 1;
            if (quiet_count >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic logic [IN_TDATA_W-1:0] pack_cmd(t_cmd c);
        logic [IN_TDATA_W-1:0] w;
        w = '0;
        w[IN_OP_LSB +: IN_OP_W]       = c.opcode;
        w[IN_VALUE_LSB +: IN_VALUE_W] = c.value;
        w[IN_INDEX_LSB +: IN_INDEX_W] = c.index;
        return w;
    endfunction

    // drive one command word and record it once accepted
    task automatic send_cmd(input t_cmd c);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_cmd(c);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_command(c);
    endtask

    task automatic send_op(input logic [3:0] op, input logic [31:0] v, input logic [5:0] idx);
        t_cmd c;
        c.opcode = op;
        c.value  = v;
        c.index  = idx;
        send_cmd(c);
    endtask

    // random command shaped by the current traffic mix
    function automatic t_cmd random_cmd(t_mix mix);
        t_cmd        c;
        int unsigned roll;
        int unsigned w_add;
        int unsigned w_del;
        int unsigned w_clear;
        int unsigned pick;
        w_add   = (mix == MIX_GROW) ? 70 : (mix == MIX_DRAIN) ? 8 : 25;
        w_del   = (mix == MIX_GROW) ? 5 : (mix == MIX_DRAIN) ? 60 : 25;
        w_clear = (mix == MIX_ANY) ? 2 : 0;
        roll    = $urandom_range(0, 99);

        case ($urandom_range(0, 9))
            0:       c.value = '0;
            1:       c.value = '1;
            2, 3, 4: c.value = $urandom_range(0, 15);
            default: c.value = $urandom;
        endcase
        c.index = $urandom_range(0, 63);

        if (roll < w_add) begin
            c.opcode = $urandom_range(0, 1) ? OP_ADD_END : OP_ADD_FRONT;
        end else if (roll < w_add + w_del) begin
            c.opcode = $urandom_range(0, 1) ? OP_DEL_END : OP_DEL_FRONT;
        end else if (roll < w_add + w_del + w_clear) begin
            c.opcode = OP_CLEAR;
        end else begin
            pick = $urandom_range(0, 19);
            if (pick <= 5) c.opcode = OP_READ;
            else if (pick <= 10) c.opcode = OP_WRITE;
            else if (pick <= 15) c.opcode = OP_FIND;
            else if (pick <= 17) c.opcode = OP_TOGGLE;
            else c.opcode = $urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST);
        end

        // mostly valid indexes, some out of range
        if ((c.opcode == OP_READ || c.opcode == OP_WRITE) && sb.fill > 0 &&
            $urandom_range(0, 4) != 0)
            c.index = $urandom_range(0, sb.fill - 1);
        // searches mostly for values that are stored
        if (c.opcode == OP_FIND && sb.fill > 0 && $urandom_range(0, 9) < 6)
            c.value = sb.element_at($urandom_range(0, sb.fill - 1));
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned sent;
        int unsigned seg_len;
        t_mix        mix;
        sb   = new();
        sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_op(OP_DEL_END,   32'h0,        6'd0);   // delete on empty
        send_op(OP_DEL_FRONT, 32'h0,        6'd0);
        send_op(OP_READ,      32'h0,        6'd0);   // read with nothing stored
        send_op(OP_FIND,      32'h0,        6'd0);   // search on empty
        send_op(OP_ADD_END,   32'h0,        6'd0);   // first add lands in slot 0
        send_op(OP_ADD_END,   32'hFFFFFFFF, 6'd63);
        send_op(OP_ADD_FRONT, 32'hA5A5A5A5, 6'd0);   // head wraps below slot 0
        send_op(OP_READ,      32'h0,        6'd0);
        send_op(OP_READ,      32'h0,        6'd2);
        send_op(OP_WRITE,     32'h5A5A5A5A, 6'd1);
        send_op(OP_WRITE,     32'h12345678, 6'd63);  // index past the count
        send_op(OP_FIND,      32'hFFFFFFFF, 6'd0);
        send_op(OP_FIND,      32'h5A5A5A5A, 6'd0);
        send_op(OP_TOGGLE,    32'h0,        6'd0);
        send_op(OP_READ,      32'h0,        6'd0);   // reversed view indexing
        send_op(OP_ADD_END,   32'h1,        6'd0);   // reversed add at end
        send_op(OP_ADD_FRONT, 32'h2,        6'd0);
        send_op(OP_FIND,      32'h1,        6'd0);
        send_op(OP_DEL_END,   32'h0,        6'd0);
        send_op(OP_DEL_FRONT, 32'h0,        6'd0);
        send_op(OP_SPARE_FIRST, 32'hFFFFFFFF, 6'd63); // ignored opcodes
        send_op(OP_SPARE_LAST,  32'h0,        6'd0);
        send_op(OP_CLEAR,     32'h0,        6'd0);   // also drops the reverse view
        send_op(OP_TOGGLE,    32'h0,        6'd0);
        send_op(OP_ADD_FRONT, 32'h7,        6'd0);   // add on empty while reversed
        send_op(OP_READ,      32'h0,        6'd0);

        // phases of growth, drain and mixed traffic
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: mix = MIX_GROW;
                4, 5, 6:    mix = MIX_DRAIN;
                default:    mix = MIX_ANY;
            endcase
            seg_len = (mix == MIX_GROW) ? $urandom_range(60, 140) : $urandom_range(30, 100);
            for (int unsigned n = 0; n < seg_len && sent < RANDOM_ITEMS; n++) begin
                if (sent >= RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
                send_cmd(random_cmd(mix));
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // let every result come back, then watch for strays
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d commands and %0d result words", sb.commands, sb.checked);
        $display("statuses: ok %0d, full %0d, empty %0d, bad index %0d, not found %0d",
                 sb.status_seen[STS_OK], sb.status_seen[STS_FULL], sb.status_seen[STS_EMPTY],
                 sb.status_seen[STS_BADIDX], sb.status_seen[STS_NOTFOUND]);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
